// File: hdl/cpu6502_enc_pkg.sv
// Package for the two-pass 6502 encoder: command and status codes,
// mode codes, mode sizes and the opcode lookup. No dependencies.
package cpu6502_enc_pkg;

  localparam logic [2:0] CMD_PASS1   = 3'd0;
  localparam logic [2:0] CMD_PASS2   = 3'd1;
  localparam logic [2:0] CMD_DEFINE  = 3'd2;
  localparam logic [2:0] CMD_MEASURE = 3'd3;
  localparam logic [2:0] CMD_EMIT    = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  localparam logic [3:0] MODE_IMPL = 4'd0;
  localparam logic [3:0] MODE_ACC  = 4'd1;
  localparam logic [3:0] MODE_ABS  = 4'd6;
  localparam logic [3:0] MODE_IND  = 4'd9;
  localparam logic [3:0] MODE_REL  = 4'd12;
  localparam logic [3:0] MODE_BYTE = 4'd13;
  localparam logic [3:0] MODE_WORD = 4'd14;

  localparam logic signed [17:0] BRANCH_MAX = 18'sd127;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] count;
    logic [1:0] status;
  } enc_result_t;

  function automatic logic [1:0] mode_size(input logic [3:0] mode);
    logic [1:0] s;
    begin
      case (mode)
        4'd0, 4'd1, 4'd13: s = 2'd1;
        4'd6, 4'd7, 4'd8, 4'd9: s = 2'd3;
        4'd15: s = 2'd0;
        default: s = 2'd2;
      endcase
      return s;
    end
  endfunction

  // Returns {found, opcode}.
  function automatic logic [8:0] find_code(input logic [3:0] mode, input logic [5:0] mn);
    logic [8:0] r;
    begin
      r = 9'h000;
      case ({mode, mn})
        {4'd0,6'd10}: r = 9'h100; {4'd0,6'd13}: r = 9'h118; {4'd0,6'd14}: r = 9'h1D8;
        {4'd0,6'd15}: r = 9'h158; {4'd0,6'd16}: r = 9'h1B8; {4'd0,6'd21}: r = 9'h1CA;
        {4'd0,6'd22}: r = 9'h188; {4'd0,6'd25}: r = 9'h1E8; {4'd0,6'd26}: r = 9'h1C8;
        {4'd0,6'd33}: r = 9'h1EA; {4'd0,6'd35}: r = 9'h148; {4'd0,6'd36}: r = 9'h108;
        {4'd0,6'd37}: r = 9'h168; {4'd0,6'd38}: r = 9'h128; {4'd0,6'd41}: r = 9'h140;
        {4'd0,6'd42}: r = 9'h160; {4'd0,6'd44}: r = 9'h138; {4'd0,6'd45}: r = 9'h1F8;
        {4'd0,6'd46}: r = 9'h178; {4'd0,6'd50}: r = 9'h1AA; {4'd0,6'd51}: r = 9'h1A8;
        {4'd0,6'd52}: r = 9'h1BA; {4'd0,6'd53}: r = 9'h18A; {4'd0,6'd54}: r = 9'h19A;
        {4'd0,6'd55}: r = 9'h198;
        {4'd1,6'd2}: r = 9'h10A; {4'd1,6'd32}: r = 9'h14A; {4'd1,6'd39}: r = 9'h12A;
        {4'd1,6'd40}: r = 9'h16A;
        {4'd2,6'd0}: r = 9'h169; {4'd2,6'd1}: r = 9'h129; {4'd2,6'd17}: r = 9'h1C9;
        {4'd2,6'd18}: r = 9'h1E0; {4'd2,6'd19}: r = 9'h1C0; {4'd2,6'd23}: r = 9'h149;
        {4'd2,6'd29}: r = 9'h1A9; {4'd2,6'd30}: r = 9'h1A2; {4'd2,6'd31}: r = 9'h1A0;
        {4'd2,6'd34}: r = 9'h109; {4'd2,6'd43}: r = 9'h1E9;
        {4'd3,6'd0}: r = 9'h165; {4'd3,6'd1}: r = 9'h125; {4'd3,6'd6}: r = 9'h124;
        {4'd3,6'd2}: r = 9'h106; {4'd3,6'd17}: r = 9'h1C5; {4'd3,6'd18}: r = 9'h1E4;
        {4'd3,6'd19}: r = 9'h1C4; {4'd3,6'd20}: r = 9'h1C6; {4'd3,6'd23}: r = 9'h145;
        {4'd3,6'd24}: r = 9'h1E6; {4'd3,6'd29}: r = 9'h1A5; {4'd3,6'd30}: r = 9'h1A6;
        {4'd3,6'd31}: r = 9'h1A4; {4'd3,6'd32}: r = 9'h146; {4'd3,6'd34}: r = 9'h105;
        {4'd3,6'd39}: r = 9'h126; {4'd3,6'd40}: r = 9'h166; {4'd3,6'd43}: r = 9'h1E5;
        {4'd3,6'd47}: r = 9'h185; {4'd3,6'd48}: r = 9'h186; {4'd3,6'd49}: r = 9'h184;
        {4'd4,6'd0}: r = 9'h175; {4'd4,6'd1}: r = 9'h135; {4'd4,6'd2}: r = 9'h116;
        {4'd4,6'd17}: r = 9'h1D5; {4'd4,6'd20}: r = 9'h1D6; {4'd4,6'd23}: r = 9'h155;
        {4'd4,6'd24}: r = 9'h1F6; {4'd4,6'd29}: r = 9'h1B5; {4'd4,6'd31}: r = 9'h1B4;
        {4'd4,6'd32}: r = 9'h156; {4'd4,6'd34}: r = 9'h115; {4'd4,6'd39}: r = 9'h136;
        {4'd4,6'd40}: r = 9'h176; {4'd4,6'd43}: r = 9'h1F5; {4'd4,6'd47}: r = 9'h195;
        {4'd4,6'd49}: r = 9'h194;
        {4'd5,6'd30}: r = 9'h1B6; {4'd5,6'd48}: r = 9'h196;
        {4'd6,6'd0}: r = 9'h16D; {4'd6,6'd1}: r = 9'h12D; {4'd6,6'd2}: r = 9'h10E;
        {4'd6,6'd6}: r = 9'h12C; {4'd6,6'd17}: r = 9'h1CD; {4'd6,6'd18}: r = 9'h1EC;
        {4'd6,6'd19}: r = 9'h1CC; {4'd6,6'd20}: r = 9'h1CE; {4'd6,6'd23}: r = 9'h14D;
        {4'd6,6'd24}: r = 9'h1EE; {4'd6,6'd27}: r = 9'h14C; {4'd6,6'd28}: r = 9'h120;
        {4'd6,6'd29}: r = 9'h1AD; {4'd6,6'd30}: r = 9'h1AE; {4'd6,6'd31}: r = 9'h1AC;
        {4'd6,6'd32}: r = 9'h14E; {4'd6,6'd34}: r = 9'h10D; {4'd6,6'd39}: r = 9'h12E;
        {4'd6,6'd40}: r = 9'h16E; {4'd6,6'd43}: r = 9'h1ED; {4'd6,6'd47}: r = 9'h18D;
        {4'd6,6'd48}: r = 9'h18E; {4'd6,6'd49}: r = 9'h18C;
        {4'd7,6'd0}: r = 9'h17D; {4'd7,6'd1}: r = 9'h13D; {4'd7,6'd2}: r = 9'h11E;
        {4'd7,6'd17}: r = 9'h1DD; {4'd7,6'd20}: r = 9'h1DE; {4'd7,6'd23}: r = 9'h15D;
        {4'd7,6'd24}: r = 9'h1FE; {4'd7,6'd29}: r = 9'h1BD; {4'd7,6'd31}: r = 9'h1BC;
        {4'd7,6'd32}: r = 9'h15E; {4'd7,6'd34}: r = 9'h11D; {4'd7,6'd39}: r = 9'h13E;
        {4'd7,6'd40}: r = 9'h17E; {4'd7,6'd43}: r = 9'h1FD; {4'd7,6'd47}: r = 9'h19D;
        {4'd8,6'd0}: r = 9'h179; {4'd8,6'd1}: r = 9'h139; {4'd8,6'd17}: r = 9'h1D9;
        {4'd8,6'd23}: r = 9'h159; {4'd8,6'd29}: r = 9'h1B9; {4'd8,6'd30}: r = 9'h1BE;
        {4'd8,6'd34}: r = 9'h119; {4'd8,6'd43}: r = 9'h1F9; {4'd8,6'd47}: r = 9'h199;
        {4'd9,6'd27}: r = 9'h16C;
        {4'd10,6'd0}: r = 9'h161; {4'd10,6'd1}: r = 9'h121; {4'd10,6'd17}: r = 9'h1C1;
        {4'd10,6'd23}: r = 9'h141; {4'd10,6'd29}: r = 9'h1A1; {4'd10,6'd34}: r = 9'h101;
        {4'd10,6'd43}: r = 9'h1E1; {4'd10,6'd47}: r = 9'h181;
        {4'd11,6'd0}: r = 9'h171; {4'd11,6'd1}: r = 9'h131; {4'd11,6'd17}: r = 9'h1D1;
        {4'd11,6'd23}: r = 9'h151; {4'd11,6'd29}: r = 9'h1B1; {4'd11,6'd34}: r = 9'h111;
        {4'd11,6'd43}: r = 9'h1F1; {4'd11,6'd47}: r = 9'h191;
        {4'd12,6'd3}: r = 9'h190; {4'd12,6'd4}: r = 9'h1B0; {4'd12,6'd5}: r = 9'h1F0;
        {4'd12,6'd7}: r = 9'h130; {4'd12,6'd8}: r = 9'h1D0; {4'd12,6'd9}: r = 9'h110;
        {4'd12,6'd11}: r = 9'h150; {4'd12,6'd12}: r = 9'h170;
        default: r = 9'h000;
      endcase
      return r;
    end
  endfunction

endpackage

// File: hdl/cpu6502_enc_labels.sv
// Label store: address memory with registered read, and valid bits that a
// start of pass one clears at once. Uses cpu6502_enc_pkg.
module cpu6502_enc_labels import cpu6502_enc_pkg::*; #(
  parameter int LABEL_COUNT = 256,
  parameter int IDX_W = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear_all,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [15:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [15:0]      rd_data,
  output logic             rd_valid
);

  logic [15:0] addr_mem [LABEL_COUNT];
  logic [LABEL_COUNT-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      addr_mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= addr_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_idx];
      end
    end
  end

endmodule

// File: hdl/cpu6502_two_pass_encoder.sv
// Top level of the two-pass 6502 encoder: command decode, label lookup,
// byte emission. Uses cpu6502_enc_pkg and cpu6502_enc_labels.

// Each item is taken in the idle state, which starts a label store read, and
// is acted on in the read state; an emit item then gives one to three bytes,
// one per cycle while the receiver is ready, and no new item is taken until the
// last byte has been sent. Label state lives in a memory with a registered read.
module cpu6502_two_pass_encoder import cpu6502_enc_pkg::*; #(
  parameter int LABEL_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], mnemonic[8:3], mode[12:9], operand_value[28:13],
  // operand_is_label[29], label_index[37:30], zero fill to 40 bits
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // status[1:0]
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (LABEL_COUNT > 1) ? $clog2(LABEL_COUNT) : 1;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state;
  logic [15:0] origin, counter;
  logic [2:0]  op;
  logic [5:0]  mn;
  logic [3:0]  mode;
  logic [15:0] val;
  logic        isl;
  logic        idx_ok;
  logic [15:0] lbl_data;
  logic        lbl_valid;
  enc_result_t res;
  logic [1:0]  sent;
  logic        in_acc;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  logic [7:0] in_idx;
  logic [2:0] in_op;
  assign in_idx = s_axis_tdata[37:30];
  assign in_op = s_axis_tdata[2:0];

  logic [IDX_W-1:0] in_idx_w;
  assign in_idx_w = IDX_W'(in_idx);

  logic in_idx_ok;
  assign in_idx_ok = ({24'd0, in_idx} < 32'(LABEL_COUNT));

  cpu6502_enc_labels #(.LABEL_COUNT(LABEL_COUNT), .IDX_W(IDX_W)) u_labels (
    .clk(clk), .rst(rst),
    .clear_all(in_acc && in_op == CMD_PASS1),
    .wr_en(in_acc && in_op == CMD_DEFINE && in_idx_ok),
    .wr_idx(in_idx_w),
    .wr_data(counter),
    .rd_en(in_acc),
    .rd_idx(in_idx_w),
    .rd_data(lbl_data),
    .rd_valid(lbl_valid)
  );

  always_comb begin
    logic [8:0] fc;
    logic [15:0] v;
    logic known;
    logic signed [17:0] diff;
    res = '0;
    fc = find_code(mode, mn);
    known = !isl || (idx_ok && lbl_valid);
    v = isl ? lbl_data + origin : val;
    diff = $signed({2'b00, v}) - $signed({2'b00, origin}) - $signed({2'b00, counter})
      - 18'sd2;
    if (mode == MODE_BYTE) begin
      res.b0 = val[7:0]; res.count = 2'd1;
    end else if (mode == MODE_WORD) begin
      if (!known) begin
        res.count = 2'd1; res.status = ST_UNKNOWN;
      end else begin
        res.b0 = v[7:0]; res.b1 = v[15:8]; res.count = 2'd2;
      end
    end else if (!fc[8]) begin
      res.count = 2'd1; res.status = ST_ILLEGAL;
    end else if (mode == MODE_IMPL || mode == MODE_ACC) begin
      res.b0 = fc[7:0]; res.count = 2'd1;
    end else if (mode == MODE_REL) begin
      if (!known) begin
        res.count = 2'd1; res.status = ST_UNKNOWN;
      end else if (diff > BRANCH_MAX || diff < -BRANCH_MAX) begin
        res.count = 2'd1; res.status = ST_RANGE;
      end else begin
        res.b0 = fc[7:0]; res.b1 = diff[7:0]; res.count = 2'd2;
      end
    end else if (mode >= MODE_ABS && mode <= MODE_IND) begin
      if (!known) begin
        res.count = 2'd1; res.status = ST_UNKNOWN;
      end else begin
        res.b0 = fc[7:0]; res.b1 = v[7:0]; res.b2 = v[15:8]; res.count = 2'd3;
      end
    end else begin
      res.b0 = fc[7:0]; res.b1 = val[7:0]; res.count = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op <= in_op;
      mn <= s_axis_tdata[8:3];
      mode <= s_axis_tdata[12:9];
      val <= s_axis_tdata[28:13];
      isl <= s_axis_tdata[29];
      idx_ok <= in_idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      origin <= '0;
      counter <= '0;
      sent <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b0;
      m_axis_tuser <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        origin <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (op == CMD_PASS1 || op == CMD_PASS2) begin
            counter <= '0;
            state <= S_IDLE;
          end else if (op == CMD_MEASURE) begin
            counter <= counter + 16'(mode_size(mode));
            state <= S_IDLE;
          end else if (op == CMD_EMIT) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= res.b0;
            m_axis_tlast <= (res.count == 2'd1);
            m_axis_tuser <= res.status;
            sent <= 2'd1;
            state <= S_OUT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            if (m_axis_tlast) begin
              m_axis_tvalid <= 1'b0;
              counter <= counter + 16'(mode_size(mode));
              state <= S_IDLE;
            end else begin
              m_axis_tdata <= (sent == 2'd1) ? res.b1 : res.b2;
              m_axis_tlast <= (sent + 2'd1 == res.count);
              sent <= sent + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_axis_tready) else $error("input taken while busy");
  a_valid_in_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (state == S_OUT)) else $error("output valid outside output state");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tlast && m_axis_tdata == 8'd0))
    else $error("error item not single zero byte");
`endif

endmodule

// File: verif/cpu6502_two_pass_encoder_tb.sv
// Self-checking testbench for the two-pass 6502 encoder: directed and random
// assembler programs are streamed in and every emitted byte is checked.
// Depends on cpu6502_enc_pkg and cpu6502_two_pass_encoder.
module cpu6502_two_pass_encoder_tb;
  import cpu6502_enc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  mnem;
    logic [3:0]  amode;
    logic [15:0] val;
    logic        is_lbl;
    logic [7:0]  lidx;
  } asm_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } code_byte_t;

  localparam int WATCHDOG_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  asm_item_t   pending_items[$];
  code_byte_t  expected_bytes[$];
  logic [9:0]  legal_pairs[$];
  asm_item_t   cur_item;

  logic [15:0] origin_reg = '0;
  logic [15:0] loc_counter = '0;
  logic [15:0] label_addr[256];
  logic        label_ok[256];

  int          send_idle = 26;
  int          recv_idle = 55;
  int          errors = 0;
  int          quiet_cycles = 0;
  int          cfg_count = 0;
  logic        cfg_req = 1'b0;
  logic [15:0] cfg_word = '0;

  cpu6502_two_pass_encoder uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [1:0] size_of_mode(logic [3:0] m);
    case (m)
      4'd0, 4'd1, 4'd13: return 2'd1;
      4'd6, 4'd7, 4'd8, 4'd9: return 2'd3;
      4'd15: return 2'd0;
      default: return 2'd2;
    endcase
  endfunction

  // Returns {legal, opcode byte}.
  function automatic logic [8:0] opcode_of(logic [3:0] m, logic [5:0] n);
    logic [7:0] c;
    logic       f;
    c = 8'h00;
    f = 1'b1;
    case (m)
      4'd0: case (n)
        10: c = 8'h00; 13: c = 8'h18; 14: c = 8'hD8; 15: c = 8'h58; 16: c = 8'hB8;
        21: c = 8'hCA; 22: c = 8'h88; 25: c = 8'hE8; 26: c = 8'hC8; 33: c = 8'hEA;
        35: c = 8'h48; 36: c = 8'h08; 37: c = 8'h68; 38: c = 8'h28; 41: c = 8'h40;
        42: c = 8'h60; 44: c = 8'h38; 45: c = 8'hF8; 46: c = 8'h78; 50: c = 8'hAA;
        51: c = 8'hA8; 52: c = 8'hBA; 53: c = 8'h8A; 54: c = 8'h9A; 55: c = 8'h98;
        default: f = 1'b0;
      endcase
      4'd1: case (n)
        2: c = 8'h0A; 32: c = 8'h4A; 39: c = 8'h2A; 40: c = 8'h6A;
        default: f = 1'b0;
      endcase
      4'd2: case (n)
        0: c = 8'h69; 1: c = 8'h29; 17: c = 8'hC9; 18: c = 8'hE0; 19: c = 8'hC0;
        23: c = 8'h49; 29: c = 8'hA9; 30: c = 8'hA2; 31: c = 8'hA0; 34: c = 8'h09;
        43: c = 8'hE9;
        default: f = 1'b0;
      endcase
      4'd3: case (n)
        0: c = 8'h65; 1: c = 8'h25; 2: c = 8'h06; 6: c = 8'h24; 17: c = 8'hC5;
        18: c = 8'hE4; 19: c = 8'hC4; 20: c = 8'hC6; 23: c = 8'h45; 24: c = 8'hE6;
        29: c = 8'hA5; 30: c = 8'hA6; 31: c = 8'hA4; 32: c = 8'h46; 34: c = 8'h05;
        39: c = 8'h26; 40: c = 8'h66; 43: c = 8'hE5; 47: c = 8'h85; 48: c = 8'h86;
        49: c = 8'h84;
        default: f = 1'b0;
      endcase
      4'd4: case (n)
        0: c = 8'h75; 1: c = 8'h35; 2: c = 8'h16; 17: c = 8'hD5; 20: c = 8'hD6;
        23: c = 8'h55; 24: c = 8'hF6; 29: c = 8'hB5; 31: c = 8'hB4; 32: c = 8'h56;
        34: c = 8'h15; 39: c = 8'h36; 40: c = 8'h76; 43: c = 8'hF5; 47: c = 8'h95;
        49: c = 8'h94;
        default: f = 1'b0;
      endcase
      4'd5: case (n)
        30: c = 8'hB6; 48: c = 8'h96;
        default: f = 1'b0;
      endcase
      4'd6: case (n)
        0: c = 8'h6D; 1: c = 8'h2D; 2: c = 8'h0E; 6: c = 8'h2C; 17: c = 8'hCD;
        18: c = 8'hEC; 19: c = 8'hCC; 20: c = 8'hCE; 23: c = 8'h4D; 24: c = 8'hEE;
        27: c = 8'h4C; 28: c = 8'h20; 29: c = 8'hAD; 30: c = 8'hAE; 31: c = 8'hAC;
        32: c = 8'h4E; 34: c = 8'h0D; 39: c = 8'h2E; 40: c = 8'h6E; 43: c = 8'hED;
        47: c = 8'h8D; 48: c = 8'h8E; 49: c = 8'h8C;
        default: f = 1'b0;
      endcase
      4'd7: case (n)
        0: c = 8'h7D; 1: c = 8'h3D; 2: c = 8'h1E; 17: c = 8'hDD; 20: c = 8'hDE;
        23: c = 8'h5D; 24: c = 8'hFE; 29: c = 8'hBD; 31: c = 8'hBC; 32: c = 8'h5E;
        34: c = 8'h1D; 39: c = 8'h3E; 40: c = 8'h7E; 43: c = 8'hFD; 47: c = 8'h9D;
        default: f = 1'b0;
      endcase
      4'd8: case (n)
        0: c = 8'h79; 1: c = 8'h39; 17: c = 8'hD9; 23: c = 8'h59; 29: c = 8'hB9;
        30: c = 8'hBE; 34: c = 8'h19; 43: c = 8'hF9; 47: c = 8'h99;
        default: f = 1'b0;
      endcase
      4'd9: case (n)
        27: c = 8'h6C;
        default: f = 1'b0;
      endcase
      4'd10, 4'd11: case (n)
        0: c = (m == 4'd10) ? 8'h61 : 8'h71;
        1: c = (m == 4'd10) ? 8'h21 : 8'h31;
        17: c = (m == 4'd10) ? 8'hC1 : 8'hD1;
        23: c = (m == 4'd10) ? 8'h41 : 8'h51;
        29: c = (m == 4'd10) ? 8'hA1 : 8'hB1;
        34: c = (m == 4'd10) ? 8'h01 : 8'h11;
        43: c = (m == 4'd10) ? 8'hE1 : 8'hF1;
        47: c = (m == 4'd10) ? 8'h81 : 8'h91;
        default: f = 1'b0;
      endcase
      4'd12: case (n)
        3: c = 8'h90; 4: c = 8'hB0; 5: c = 8'hF0; 7: c = 8'h30; 8: c = 8'hD0;
        9: c = 8'h10; 11: c = 8'h50; 12: c = 8'h70;
        default: f = 1'b0;
      endcase
      default: f = 1'b0;
    endcase
    return {f, c};
  endfunction

  task automatic push_byte(logic [7:0] b, logic l, logic [1:0] s);
    code_byte_t e;
    e.data = b;
    e.last = l;
    e.status = s;
    expected_bytes.push_back(e);
  endtask

  // Operand value of a label reference or literal; returns the status.
  function automatic logic [1:0] operand_of(asm_item_t it, output logic [15:0] v);
    v = it.val;
    if (!it.is_lbl) return ST_OK;
    if (!label_ok[it.lidx]) return ST_UNKNOWN;
    v = label_addr[it.lidx] + origin_reg;
    return ST_OK;
  endfunction

  task automatic encode_item(asm_item_t it);
    logic [8:0]  oc;
    logic [15:0] v;
    logic [1:0]  st;
    int          diff;
    oc = opcode_of(it.amode, it.mnem);
    if (it.amode == MODE_BYTE) begin
      push_byte(it.val[7:0], 1'b1, ST_OK);
    end else if (it.amode == MODE_WORD) begin
      st = operand_of(it, v);
      if (st != ST_OK) push_byte(8'h00, 1'b1, st);
      else begin
        push_byte(v[7:0], 1'b0, ST_OK);
        push_byte(v[15:8], 1'b1, ST_OK);
      end
    end else if (!oc[8]) begin
      push_byte(8'h00, 1'b1, ST_ILLEGAL);
    end else if (it.amode <= MODE_ACC) begin
      push_byte(oc[7:0], 1'b1, ST_OK);
    end else if (it.amode == MODE_REL) begin
      st = operand_of(it, v);
      diff = int'(v) - (int'(origin_reg) + int'(loc_counter) + 2);
      if (st != ST_OK) push_byte(8'h00, 1'b1, st);
      else if (diff > 127 || diff < -127) push_byte(8'h00, 1'b1, ST_RANGE);
      else begin
        push_byte(oc[7:0], 1'b0, ST_OK);
        push_byte(diff[7:0], 1'b1, ST_OK);
      end
    end else if (it.amode >= MODE_ABS && it.amode <= MODE_IND) begin
      st = operand_of(it, v);
      if (st != ST_OK) push_byte(8'h00, 1'b1, st);
      else begin
        push_byte(oc[7:0], 1'b0, ST_OK);
        push_byte(v[7:0], 1'b0, ST_OK);
        push_byte(v[15:8], 1'b1, ST_OK);
      end
    end else begin
      push_byte(oc[7:0], 1'b0, ST_OK);
      push_byte(it.val[7:0], 1'b1, ST_OK);
    end
  endtask

  task automatic assemble_step(asm_item_t it);
    case (it.op)
      CMD_PASS1: begin
        foreach (label_ok[i]) label_ok[i] = 1'b0;
        loc_counter = '0;
      end
      CMD_PASS2: loc_counter = '0;
      CMD_DEFINE: begin
        label_addr[it.lidx] = loc_counter;
        label_ok[it.lidx] = 1'b1;
      end
      CMD_MEASURE: loc_counter = loc_counter + size_of_mode(it.amode);
      CMD_EMIT: begin
        encode_item(it);
        loc_counter = loc_counter + size_of_mode(it.amode);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // Input driver, configuration writes and the running model.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) assemble_step(cur_item);
      if ((!s_axis_tvalid || s_axis_tready) && pending_items.size() != 0 &&
          $urandom_range(0, 99) >= send_idle) begin
        cur_item = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, cur_item.lidx, cur_item.is_lbl, cur_item.val,
                         cur_item.amode, cur_item.mnem, cur_item.op};
      end else if (!s_axis_tvalid || s_axis_tready) begin
        s_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        origin_reg = cfg_data;
        cfg_valid <= 1'b0;
        cfg_count++;
      end else if (!cfg_valid && cfg_req) begin
        cfg_valid <= 1'b1;
        cfg_data <= cfg_word;
        cfg_req = 1'b0;
      end
    end
  end

  // Output monitor, receiver stalls and watchdog.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata, 0);
        end else begin
          code_byte_t e;
          e = expected_bytes.pop_front();
          if (m_axis_tdata !== e.data) report_mismatch("out_byte", m_axis_tdata, e.data);
          if (m_axis_tlast !== e.last) report_mismatch("last", m_axis_tlast, e.last);
          if (m_axis_tuser !== e.status) report_mismatch("status", m_axis_tuser, e.status);
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("cpu6502_two_pass_encoder_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic add_item(logic [2:0] op, logic [5:0] mn, logic [3:0] m,
                          logic [15:0] v, logic isl, logic [7:0] idx);
    asm_item_t it;
    it.op = op;
    it.mnem = mn;
    it.amode = m;
    it.val = v;
    it.is_lbl = isl;
    it.lidx = idx;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_origin(logic [15:0] v);
    int k;
    k = cfg_count;
    cfg_word = v;
    cfg_req = 1'b1;
    wait (cfg_count == k + 1);
  endtask

  // A random program: both passes over the same statements, plus some noise.
  task automatic add_program(int n);
    asm_item_t   stmts[$];
    asm_item_t   it;
    logic [7:0]  pool[4];
    logic [9:0]  pr;
    foreach (pool[i]) pool[i] = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      it.val = $urandom_range(0, 65535);
      it.lidx = pool[$urandom_range(0, 3)];
      it.is_lbl = $urandom_range(0, 1);
      it.mnem = $urandom_range(0, 63);
      if ($urandom_range(0, 99) < 20) begin
        it.op = CMD_DEFINE;
        it.amode = $urandom_range(0, 15);
      end else begin
        it.op = CMD_EMIT;
        case ($urandom_range(0, 9))
          0: it.amode = MODE_BYTE;
          1: it.amode = MODE_WORD;
          2: it.amode = $urandom_range(0, 15);
          default: begin
            pr = legal_pairs[$urandom_range(0, legal_pairs.size() - 1)];
            it.amode = pr[9:6];
            it.mnem = pr[5:0];
          end
        endcase
        if (it.amode == MODE_REL && $urandom_range(0, 3) != 0) it.is_lbl = 1'b1;
      end
      stmts.push_back(it);
    end
    add_item(CMD_PASS1, $urandom_range(0, 63), $urandom_range(0, 15), 16'h0, 1'b0, 8'h0);
    foreach (stmts[i]) begin
      it = stmts[i];
      if (it.op == CMD_EMIT) it.op = CMD_MEASURE;
      pending_items.push_back(it);
    end
    add_item(CMD_PASS2, 6'd0, 4'd0, $urandom_range(0, 65535), 1'b1, 8'hFF);
    foreach (stmts[i]) begin
      if ($urandom_range(0, 99) < 8)
        add_item($urandom_range(1, 7), $urandom_range(0, 63), $urandom_range(0, 15),
                 $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 255));
      pending_items.push_back(stmts[i]);
    end
  endtask

  task automatic random_phase(int count);
    int added;
    added = 0;
    while (added < count) begin
      int before_n;
      before_n = pending_items.size();
      add_program($urandom_range(3, 12));
      added += pending_items.size() - before_n;
    end
  endtask

  initial begin
    for (int m = 0; m < 16; m++)
      for (int n = 0; n < 64; n++)
        if (opcode_of(m[3:0], n[5:0]) >> 8) legal_pairs.push_back({m[3:0], n[5:0]});
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_idle = 26;
    recv_idle = 55;
    write_origin(16'h1000);
    add_item(CMD_PASS2, 6'd0, 4'd0, 16'h0, 1'b0, 8'h0);
    add_item(CMD_EMIT, 6'd3, MODE_REL, 16'h1002 + 16'd127, 1'b0, 8'h0);
    add_item(CMD_EMIT, 6'd4, MODE_REL, 16'h1004 - 16'd127, 1'b0, 8'h0);
    add_item(CMD_EMIT, 6'd5, MODE_REL, 16'h1006 - 16'd128, 1'b0, 8'h0);
    add_item(CMD_EMIT, 6'd12, MODE_REL, 16'h1008 + 16'd128, 1'b0, 8'h0);
    add_item(CMD_PASS1, 6'd0, 4'd0, 16'h0, 1'b0, 8'h0);
    add_item(CMD_DEFINE, 6'd0, 4'd0, 16'h0, 1'b0, 8'd0);
    add_item(CMD_EMIT, 6'd33, MODE_IMPL, 16'hFFFF, 1'b1, 8'd7);
    add_item(CMD_EMIT, 6'd2, MODE_ACC, 16'h0, 1'b0, 8'd0);
    add_item(CMD_EMIT, 6'd29, 4'd2, 16'hFFFF, 1'b1, 8'd0);
    add_item(CMD_EMIT, 6'd47, 4'd3, 16'h0000, 1'b0, 8'd0);
    add_item(CMD_DEFINE, 6'd0, 4'd0, 16'h0, 1'b0, 8'd255);
    add_item(CMD_EMIT, 6'd0, MODE_ABS, 16'hFFFF, 1'b0, 8'd0);
    add_item(CMD_EMIT, 6'd27, MODE_IND, 16'h0, 1'b1, 8'd255);
    add_item(CMD_EMIT, 6'd3, MODE_REL, 16'h0, 1'b1, 8'd0);
    add_item(CMD_EMIT, 6'd63, MODE_BYTE, 16'hFFAB, 1'b1, 8'd99);
    add_item(CMD_EMIT, 6'd63, MODE_WORD, 16'h0, 1'b1, 8'd255);
    add_item(CMD_EMIT, 6'd0, MODE_WORD, 16'h0, 1'b1, 8'd100);
    add_item(CMD_EMIT, 6'd28, MODE_ABS, 16'h0, 1'b1, 8'd100);
    add_item(CMD_EMIT, 6'd33, 4'd2, 16'h0, 1'b0, 8'd0);
    add_item(CMD_EMIT, 6'd33, 4'd15, 16'h0, 1'b0, 8'd0);
    add_item(CMD_MEASURE, 6'd0, 4'd15, 16'h0, 1'b0, 8'd0);
    add_item(3'd5, 6'd0, 4'd0, 16'h0, 1'b0, 8'd0);
    add_item(3'd7, 6'd63, 4'd15, 16'hFFFF, 1'b1, 8'hFF);
    add_item(CMD_EMIT, 6'd29, 4'd11, 16'h00FF, 1'b0, 8'd0);
    wait_idle();

    write_origin(16'h0000);
    random_phase(40);
    wait_idle();

    send_idle = 55;
    recv_idle = 26;
    write_origin(16'hFFFF);
    random_phase(40);
    wait_idle();

    send_idle = 0;
    recv_idle = 0;
    write_origin($urandom_range(0, 65535));
    random_phase(40);
    wait_idle();

    if (errors == 0) begin
      $display("cpu6502_two_pass_encoder_tb OK");
    end else begin
      $display("cpu6502_two_pass_encoder_tb NOT OK");
    end
    $finish;
  end
endmodule

// File: cpu6502_two_pass_encoder.f
hdl/cpu6502_enc_pkg.sv
hdl/cpu6502_enc_labels.sv
hdl/cpu6502_two_pass_encoder.sv
verif/cpu6502_two_pass_encoder_tb.sv
